>>> rtl/core/rtqi_pkg.sv
// ----------------------------------------------------------------------------
// rtqi_pkg
// Shared widths, codes and types for the ray / triangle-parallelogram
// intersection pipeline.
// ----------------------------------------------------------------------------
package rtqi_pkg;

   localparam int COORD_BITS = 21;
   localparam int PACK_BITS  = 3 * COORD_BITS;
   localparam int T_BITS     = 32;
   localparam int T_FRAC     = 16;
   localparam int BARY_BITS  = 15;
   localparam int BARY_FRAC  = 14;
   localparam int QUO_BITS   = 32;
   // det and the three numerators, with headroom
   localparam int NUM_BITS   = 3 * COORD_BITS + 4;

   localparam logic OP_TRI  = 1'b0;
   localparam logic OP_QUAD = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [PACK_BITS-1:0]         pack_type;

   // one divider stage: three lanes (t, b1, b2) sharing the divisor
   typedef struct packed {
      logic                           hit;
      logic                           front;
      logic                           tneg;
      logic [NUM_BITS-1:0]            adet;
      pack_type                       org;
      pack_type                       dir;
      logic [2:0][NUM_BITS-1:0]       rem;
      logic [2:0][QUO_BITS-1:0]       pend;
      logic [2:0][QUO_BITS-1:0]       quo;
   } div_type;

   function automatic coord_type get_coord(pack_type v, int unsigned idx);
      return v[idx*COORD_BITS +: COORD_BITS];
   endfunction

endpackage

>>> rtl/core/rtqi_if.sv
// ----------------------------------------------------------------------------
// rtqi_if
// Valid/ready channels for ray-primitive requests and intersection responses.
// ----------------------------------------------------------------------------
interface rtqi_req_if;
   import rtqi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [PACK_BITS-1:0]      ray_origin;
   logic [PACK_BITS-1:0]      ray_direction;
   logic [PACK_BITS-1:0]      vertex0;
   logic [PACK_BITS-1:0]      edge1;
   logic [PACK_BITS-1:0]      edge2;
   logic signed [T_BITS-1:0]  t_min;
   logic signed [T_BITS-1:0]  t_max;

   modport source (output valid, op, ray_origin, ray_direction, vertex0, edge1, edge2,
                   t_min, t_max, input ready);
   modport sink   (input valid, op, ray_origin, ray_direction, vertex0, edge1, edge2,
                   t_min, t_max, output ready);
endinterface

interface rtqi_rsp_if;
   import rtqi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [T_BITS-1:0]  hit_t;
   logic [BARY_BITS-1:0]      bary_u;
   logic [BARY_BITS-1:0]      bary_v;
   logic                      front_face;
   logic [PACK_BITS-1:0]      hit_point;

   modport source (output valid, hit, hit_t, bary_u, bary_v, front_face, hit_point,
                   input ready);
   modport sink   (input valid, hit, hit_t, bary_u, bary_v, front_face, hit_point,
                   output ready);
endinterface

>>> rtl/core/ray_triangle_quad_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_quad_intersect
// Fixed-point Moller-Trumbore test of one ray against one triangle or
// parallelogram per cycle, with t, barycentrics, facing and hit point.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  req     | in  | valid / ready    | op, ray, primitive, t interval
//  rsp     | out | valid / ready    | hit, t, b1, b2, front, hit point
//
//  One item per cycle while the pipeline is not held: cross and dot products,
//  a setup stage, restoring division (one quotient bit per stage, three
//  lanes in parallel), then the hit point and output registers.
//  Synchronous reset clears the valid bits only.
//  The whole pipeline holds while the output register is full and not taken.
// ----------------------------------------------------------------------------
module ray_triangle_quad_intersect (
   input  logic        clock,
   input  logic        reset,
   rtqi_req_if.sink    req,
   rtqi_rsp_if.source  rsp
);
   import rtqi_pkg::*;

   localparam int SUB_BITS = COORD_BITS + 1;
   localparam int PM_BITS  = 2 * COORD_BITS;
   localparam int QM_BITS  = 2 * COORD_BITS + 1;
   localparam int P_BITS   = 2 * COORD_BITS + 1;
   localparam int Q_BITS   = 2 * COORD_BITS + 2;
   localparam int PRD_BITS = 3 * COORD_BITS + 2;
   localparam int SPLIT    = 32;
   localparam int LP_BITS  = T_BITS + SPLIT + 1;
   localparam int HP_BITS  = T_BITS + NUM_BITS - SPLIT + 1;
   localparam int MW_BITS  = NUM_BITS + T_BITS + 1;
   localparam int SC_BITS  = NUM_BITS + T_FRAC;
   localparam int TD_BITS  = T_BITS + COORD_BITS;
   localparam int NX1 [3]  = '{1, 2, 0};
   localparam int NX2 [3]  = '{2, 0, 1};
   localparam logic signed [TD_BITS:0] C_MAX = (TD_BITS+1)'((1 << (COORD_BITS-1)) - 1);
   localparam logic signed [TD_BITS:0] C_MIN = -(TD_BITS+1)'(1 << (COORD_BITS-1));
   localparam logic signed [TD_BITS-1:0] T_RND = TD_BITS'((1 << T_FRAC) - 1);

   logic en;

   // stage 1
   logic                        s1_vld_ff, s1_quad_ff;
   pack_type                    s1_o_ff, s1_d_ff;
   coord_type                   s1_e1_ff [3], s1_e2_ff [3];
   logic signed [SUB_BITS-1:0]  s1_s_ff [3];
   logic signed [T_BITS-1:0]    s1_tmin_ff, s1_tmax_ff;
   // stage 2
   logic                        s2_vld_ff, s2_quad_ff;
   pack_type                    s2_o_ff, s2_d_ff;
   coord_type                   s2_e1_ff [3], s2_e2_ff [3];
   logic signed [SUB_BITS-1:0]  s2_s_ff [3];
   logic signed [T_BITS-1:0]    s2_tmin_ff, s2_tmax_ff;
   logic signed [PM_BITS-1:0]   s2_pa_ff [3], s2_pb_ff [3];
   logic signed [QM_BITS-1:0]   s2_qa_ff [3], s2_qb_ff [3];
   // stage 3
   logic                        s3_vld_ff, s3_quad_ff;
   pack_type                    s3_o_ff, s3_d_ff;
   coord_type                   s3_e1_ff [3], s3_e2_ff [3];
   logic signed [SUB_BITS-1:0]  s3_s_ff [3];
   logic signed [T_BITS-1:0]    s3_tmin_ff, s3_tmax_ff;
   logic signed [P_BITS-1:0]    s3_p_ff [3];
   logic signed [Q_BITS-1:0]    s3_q_ff [3];
   // stage 4
   logic                        s4_vld_ff, s4_quad_ff;
   pack_type                    s4_o_ff, s4_d_ff;
   logic signed [T_BITS-1:0]    s4_tmin_ff, s4_tmax_ff;
   logic signed [PRD_BITS-1:0]  s4_dt_ff [3], s4_tt_ff [3], s4_ut_ff [3], s4_vt_ff [3];
   // stage 5
   logic                        s5_vld_ff, s5_quad_ff;
   pack_type                    s5_o_ff, s5_d_ff;
   logic signed [T_BITS-1:0]    s5_tmin_ff, s5_tmax_ff;
   logic signed [NUM_BITS-1:0]  s5_det_ff, s5_nt_ff, s5_n1_ff, s5_n2_ff;
   // stage 6
   logic                        s6_vld_ff, s6_quad_ff, s6_nz_ff, s6_front_ff;
   pack_type                    s6_o_ff, s6_d_ff;
   logic signed [T_BITS-1:0]    s6_tmin_ff, s6_tmax_ff;
   logic [NUM_BITS-1:0]         s6_adet_ff;
   logic signed [NUM_BITS-1:0]  s6_nt_ff, s6_n1_ff, s6_n2_ff;
   // stage 7 interval products, aligned with divider stage 0
   logic signed [LP_BITS-1:0]   s7_lmin_ff, s7_lmax_ff;
   logic signed [HP_BITS-1:0]   s7_hmin_ff, s7_hmax_ff;
   logic signed [SC_BITS-1:0]   s7_scaled_ff;
   logic                        s7_bok_ff;
   // divider
   logic                        dv_vld_ff [0:QUO_BITS];
   div_type                     dv_ff [0:QUO_BITS];
   div_type                     dv_in [1:QUO_BITS];
   logic                        hit_in;
   // finish
   logic                        f1_vld_ff, f1_hit_ff, f1_front_ff;
   pack_type                    f1_o_ff, f1_d_ff;
   logic signed [T_BITS-1:0]    f1_ts_ff;
   logic [BARY_BITS-1:0]        f1_bu_ff, f1_bv_ff;
   logic                        f2_vld_ff, f2_hit_ff, f2_front_ff;
   pack_type                    f2_o_ff;
   logic signed [T_BITS-1:0]    f2_ts_ff;
   logic [BARY_BITS-1:0]        f2_bu_ff, f2_bv_ff;
   logic signed [TD_BITS-1:0]   f2_td_ff [3];
   pack_type                    pt_in;
   // output register
   logic                        out_vld_ff, out_hit_ff, out_front_ff;
   logic signed [T_BITS-1:0]    out_t_ff;
   logic [BARY_BITS-1:0]        out_bu_ff, out_bv_ff;
   pack_type                    out_pt_ff;

   // unpacked views
   coord_type s1_dv [3], s3_dv [3], f1_dv [3], f2_ov [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s1_dv[k] = get_coord(s1_d_ff, k);
         s3_dv[k] = get_coord(s3_d_ff, k);
         f1_dv[k] = get_coord(f1_d_ff, k);
         f2_ov[k] = get_coord(f2_o_ff, k);
      end
   end

   assign en        = !out_vld_ff || rsp.ready;
   assign req.ready = en;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         for (int k = 0; k <= QUO_BITS; k++) dv_vld_ff[k] <= 1'b0;
         f1_vld_ff  <= 1'b0;
         f2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff    <= req.valid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         s5_vld_ff    <= s4_vld_ff;
         s6_vld_ff    <= s5_vld_ff;
         dv_vld_ff[0] <= s6_vld_ff;
         for (int k = 1; k <= QUO_BITS; k++) dv_vld_ff[k] <= dv_vld_ff[k-1];
         f1_vld_ff    <= dv_vld_ff[QUO_BITS];
         f2_vld_ff    <= f1_vld_ff;
         out_vld_ff   <= f2_vld_ff;
      end
   end

   // front end: S = O - V, cross products, dot products, sign fix
   always_ff @(posedge clock) begin
      if (en) begin
         s1_quad_ff <= (req.op == OP_QUAD);
         s1_o_ff    <= req.ray_origin;
         s1_d_ff    <= req.ray_direction;
         s1_tmin_ff <= req.t_min;
         s1_tmax_ff <= req.t_max;
         for (int k = 0; k < 3; k++) begin
            s1_e1_ff[k] <= get_coord(req.edge1, k);
            s1_e2_ff[k] <= get_coord(req.edge2, k);
            s1_s_ff[k]  <= SUB_BITS'(get_coord(req.ray_origin, k))
                         - SUB_BITS'(get_coord(req.vertex0, k));
         end

         s2_quad_ff <= s1_quad_ff;
         s2_o_ff    <= s1_o_ff;
         s2_d_ff    <= s1_d_ff;
         s2_tmin_ff <= s1_tmin_ff;
         s2_tmax_ff <= s1_tmax_ff;
         s2_e1_ff   <= s1_e1_ff;
         s2_e2_ff   <= s1_e2_ff;
         s2_s_ff    <= s1_s_ff;
         for (int k = 0; k < 3; k++) begin
            s2_pa_ff[k] <= s1_dv[NX1[k]] * s1_e2_ff[NX2[k]];
            s2_pb_ff[k] <= s1_dv[NX2[k]] * s1_e2_ff[NX1[k]];
            s2_qa_ff[k] <= s1_s_ff[NX1[k]] * s1_e1_ff[NX2[k]];
            s2_qb_ff[k] <= s1_s_ff[NX2[k]] * s1_e1_ff[NX1[k]];
         end

         s3_quad_ff <= s2_quad_ff;
         s3_o_ff    <= s2_o_ff;
         s3_d_ff    <= s2_d_ff;
         s3_tmin_ff <= s2_tmin_ff;
         s3_tmax_ff <= s2_tmax_ff;
         s3_e1_ff   <= s2_e1_ff;
         s3_e2_ff   <= s2_e2_ff;
         s3_s_ff    <= s2_s_ff;
         for (int k = 0; k < 3; k++) begin
            s3_p_ff[k] <= P_BITS'(s2_pa_ff[k]) - P_BITS'(s2_pb_ff[k]);
            s3_q_ff[k] <= Q_BITS'(s2_qa_ff[k]) - Q_BITS'(s2_qb_ff[k]);
         end

         s4_quad_ff <= s3_quad_ff;
         s4_o_ff    <= s3_o_ff;
         s4_d_ff    <= s3_d_ff;
         s4_tmin_ff <= s3_tmin_ff;
         s4_tmax_ff <= s3_tmax_ff;
         for (int k = 0; k < 3; k++) begin
            s4_dt_ff[k] <= s3_p_ff[k] * s3_e1_ff[k];
            s4_tt_ff[k] <= s3_q_ff[k] * s3_e2_ff[k];
            s4_ut_ff[k] <= s3_p_ff[k] * s3_s_ff[k];
            s4_vt_ff[k] <= s3_q_ff[k] * s3_dv[k];
         end

         s5_quad_ff <= s4_quad_ff;
         s5_o_ff    <= s4_o_ff;
         s5_d_ff    <= s4_d_ff;
         s5_tmin_ff <= s4_tmin_ff;
         s5_tmax_ff <= s4_tmax_ff;
         s5_det_ff  <= NUM_BITS'(s4_dt_ff[0]) + NUM_BITS'(s4_dt_ff[1])
                     + NUM_BITS'(s4_dt_ff[2]);
         s5_nt_ff   <= NUM_BITS'(s4_tt_ff[0]) + NUM_BITS'(s4_tt_ff[1])
                     + NUM_BITS'(s4_tt_ff[2]);
         s5_n1_ff   <= NUM_BITS'(s4_ut_ff[0]) + NUM_BITS'(s4_ut_ff[1])
                     + NUM_BITS'(s4_ut_ff[2]);
         s5_n2_ff   <= NUM_BITS'(s4_vt_ff[0]) + NUM_BITS'(s4_vt_ff[1])
                     + NUM_BITS'(s4_vt_ff[2]);

         // fold the sign of det into the numerators
         s6_quad_ff  <= s5_quad_ff;
         s6_o_ff     <= s5_o_ff;
         s6_d_ff     <= s5_d_ff;
         s6_tmin_ff  <= s5_tmin_ff;
         s6_tmax_ff  <= s5_tmax_ff;
         s6_nz_ff    <= (s5_det_ff != '0);
         s6_front_ff <= !s5_det_ff[NUM_BITS-1] && (s5_det_ff != '0);
         if (s5_det_ff[NUM_BITS-1]) begin
            s6_adet_ff <= -s5_det_ff;
            s6_nt_ff   <= -s5_nt_ff;
            s6_n1_ff   <= -s5_n1_ff;
            s6_n2_ff   <= -s5_n2_ff;
         end else begin
            s6_adet_ff <= s5_det_ff;
            s6_nt_ff   <= s5_nt_ff;
            s6_n1_ff   <= s5_n1_ff;
            s6_n2_ff   <= s5_n2_ff;
         end
      end
   end

   // setup: barycentric range, interval products, divider lanes
   logic signed [NUM_BITS:0]   st_sum, st_adet, st_n1, st_n2;
   logic                       st_bok, st_tneg;
   logic [NUM_BITS-1:0]        st_mag;
   always_comb begin
      st_n1   = (NUM_BITS+1)'(s6_n1_ff);
      st_n2   = (NUM_BITS+1)'(s6_n2_ff);
      st_adet = $signed({1'b0, s6_adet_ff});
      st_sum  = st_n1 + st_n2;
      st_bok  = s6_nz_ff && !s6_n1_ff[NUM_BITS-1] && !s6_n2_ff[NUM_BITS-1]
             && (s6_quad_ff ? (st_n1 <= st_adet && st_n2 <= st_adet)
                            : (st_sum <= st_adet));
      st_tneg = s6_nt_ff[NUM_BITS-1];
      st_mag  = st_tneg ? NUM_BITS'(-s6_nt_ff) : NUM_BITS'(s6_nt_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_bok_ff    <= st_bok;
         s7_scaled_ff <= {s6_nt_ff, {T_FRAC{1'b0}}};
         s7_lmin_ff   <= s6_tmin_ff * $signed({1'b0, s6_adet_ff[SPLIT-1:0]});
         s7_lmax_ff   <= s6_tmax_ff * $signed({1'b0, s6_adet_ff[SPLIT-1:0]});
         s7_hmin_ff   <= s6_tmin_ff * $signed({1'b0, s6_adet_ff[NUM_BITS-1:SPLIT]});
         s7_hmax_ff   <= s6_tmax_ff * $signed({1'b0, s6_adet_ff[NUM_BITS-1:SPLIT]});

         dv_ff[0].hit     <= 1'b0;
         dv_ff[0].front   <= s6_front_ff;
         dv_ff[0].tneg    <= st_tneg;
         dv_ff[0].adet    <= s6_adet_ff;
         dv_ff[0].org     <= s6_o_ff;
         dv_ff[0].dir     <= s6_d_ff;
         dv_ff[0].quo     <= '0;
         // dividend = x << frac; the top part seeds the remainder
         dv_ff[0].rem[0]  <= st_mag >> (QUO_BITS - T_FRAC);
         dv_ff[0].pend[0] <= {st_mag[QUO_BITS-T_FRAC-1:0], {T_FRAC{1'b0}}};
         dv_ff[0].rem[1]  <= NUM_BITS'(s6_n1_ff) >> (QUO_BITS - BARY_FRAC);
         dv_ff[0].pend[1] <= {s6_n1_ff[QUO_BITS-BARY_FRAC-1:0], {BARY_FRAC{1'b0}}};
         dv_ff[0].rem[2]  <= NUM_BITS'(s6_n2_ff) >> (QUO_BITS - BARY_FRAC);
         dv_ff[0].pend[2] <= {s6_n2_ff[QUO_BITS-BARY_FRAC-1:0], {BARY_FRAC{1'b0}}};

         for (int k = 1; k <= QUO_BITS; k++) dv_ff[k] <= dv_in[k];
      end
   end

   // interval test: tmin*det < nt<<16 < tmax*det, exact
   logic signed [MW_BITS-1:0] tmin_det, tmax_det, scaled_w;
   always_comb begin
      tmin_det = (MW_BITS'(s7_hmin_ff) <<< SPLIT) + MW_BITS'(s7_lmin_ff);
      tmax_det = (MW_BITS'(s7_hmax_ff) <<< SPLIT) + MW_BITS'(s7_lmax_ff);
      scaled_w = MW_BITS'(s7_scaled_ff);
      hit_in   = s7_bok_ff && (tmin_det < scaled_w) && (scaled_w < tmax_det);
   end

   // restoring division, one quotient bit per stage per lane
   logic [NUM_BITS:0] dv_r2;
   logic              dv_ge;
   always_comb begin
      dv_r2 = '0;
      dv_ge = 1'b0;
      for (int k = 1; k <= QUO_BITS; k++) begin
         dv_in[k] = dv_ff[k-1];
         for (int j = 0; j < 3; j++) begin
            dv_r2 = {dv_ff[k-1].rem[j], dv_ff[k-1].pend[j][QUO_BITS-1]};
            dv_ge = (dv_r2 >= {1'b0, dv_ff[k-1].adet});
            dv_in[k].rem[j]  = dv_ge ? NUM_BITS'(dv_r2 - {1'b0, dv_ff[k-1].adet})
                                     : NUM_BITS'(dv_r2);
            dv_in[k].pend[j] = {dv_ff[k-1].pend[j][QUO_BITS-2:0], 1'b0};
            dv_in[k].quo[j]  = {dv_ff[k-1].quo[j][QUO_BITS-2:0], dv_ge};
         end
      end
      dv_in[1].hit = hit_in;
   end

   // hit point: O + trunc(t*D / 2^16), saturated
   logic signed [TD_BITS-1:0] hp_adj, hp_sh;
   logic signed [TD_BITS:0]   hp_c;
   always_comb begin
      pt_in  = '0;
      hp_adj = '0;
      hp_sh  = '0;
      hp_c   = '0;
      for (int k = 0; k < 3; k++) begin
         hp_adj = f2_td_ff[k][TD_BITS-1] ? f2_td_ff[k] + T_RND : f2_td_ff[k];
         hp_sh  = hp_adj >>> T_FRAC;
         hp_c   = (TD_BITS+1)'(hp_sh) + (TD_BITS+1)'(f2_ov[k]);
         if (hp_c > C_MAX)      hp_c = C_MAX;
         else if (hp_c < C_MIN) hp_c = C_MIN;
         pt_in[k*COORD_BITS +: COORD_BITS] = hp_c[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_hit_ff   <= dv_ff[QUO_BITS].hit;
         f1_front_ff <= dv_ff[QUO_BITS].front;
         f1_o_ff     <= dv_ff[QUO_BITS].org;
         f1_d_ff     <= dv_ff[QUO_BITS].dir;
         f1_ts_ff    <= dv_ff[QUO_BITS].tneg ? -$signed(dv_ff[QUO_BITS].quo[0])
                                             :  $signed(dv_ff[QUO_BITS].quo[0]);
         f1_bu_ff    <= dv_ff[QUO_BITS].quo[1][BARY_BITS-1:0];
         f1_bv_ff    <= dv_ff[QUO_BITS].quo[2][BARY_BITS-1:0];

         f2_hit_ff   <= f1_hit_ff;
         f2_front_ff <= f1_front_ff;
         f2_o_ff     <= f1_o_ff;
         f2_ts_ff    <= f1_ts_ff;
         f2_bu_ff    <= f1_bu_ff;
         f2_bv_ff    <= f1_bv_ff;
         for (int k = 0; k < 3; k++) f2_td_ff[k] <= f1_ts_ff * f1_dv[k];

         // a miss reports all zeros
         out_hit_ff   <= f2_hit_ff;
         out_front_ff <= f2_hit_ff && f2_front_ff;
         out_t_ff     <= f2_hit_ff ? f2_ts_ff : '0;
         out_bu_ff    <= f2_hit_ff ? f2_bu_ff : '0;
         out_bv_ff    <= f2_hit_ff ? f2_bv_ff : '0;
         out_pt_ff    <= f2_hit_ff ? pt_in : '0;
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.hit        = out_hit_ff;
   assign rsp.hit_t      = out_t_ff;
   assign rsp.bary_u     = out_bu_ff;
   assign rsp.bary_v     = out_bv_ff;
   assign rsp.front_face = out_front_ff;
   assign rsp.hit_point  = out_pt_ff;

endmodule

>>> verif/rtqi_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtqi_checker
// Watches the request and response channels of the intersection block,
// predicts each response from the accepted request and compares the fields.
// ----------------------------------------------------------------------------
module rtqi_checker (
   input  logic clock,
   input  logic reset,
   rtqi_req_if  req,
   rtqi_rsp_if  rsp,
   output int   fail_count,
   output int   pending,
   output int   req_count,
   output int   hit_count,
   output int   quad_count
);
   import rtqi_pkg::*;

   typedef logic signed [127:0] wide_t;

   typedef struct packed {
      logic                    hit;
      logic signed [T_BITS-1:0] hit_t;
      logic [BARY_BITS-1:0]    bary_u;
      logic [BARY_BITS-1:0]    bary_v;
      logic                    front_face;
      pack_type                hit_point;
   } isect_t;

   isect_t isect_q[$];

   function automatic wide_t coord_of(pack_type v, int idx);
      coord_type c;
      c = v[idx*COORD_BITS +: COORD_BITS];
      return wide_t'(c);
   endfunction

   function automatic isect_t predict_intersection(
      input logic op, input pack_type o_p, input pack_type d_p, input pack_type v_p,
      input pack_type e1_p, input pack_type e2_p,
      input logic signed [T_BITS-1:0] t_lo, input logic signed [T_BITS-1:0] t_hi);
      wide_t o[3], d[3], s[3], e1[3], e2[3], p[3], q[3];
      wide_t det, nt, n1, n2, scaled, mag, tq, bu, bv, c, lim, lo_b, hi_b;
      longint ts;
      logic ok;
      isect_t r;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         o[i]  = coord_of(o_p, i);
         d[i]  = coord_of(d_p, i);
         s[i]  = o[i] - coord_of(v_p, i);
         e1[i] = coord_of(e1_p, i);
         e2[i] = coord_of(e2_p, i);
      end
      p[0] = d[1]*e2[2] - d[2]*e2[1];
      p[1] = d[2]*e2[0] - d[0]*e2[2];
      p[2] = d[0]*e2[1] - d[1]*e2[0];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      det = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
      if (det == 0) return r;
      nt = q[0]*e2[0] + q[1]*e2[1] + q[2]*e2[2];
      n1 = p[0]*s[0] + p[1]*s[1] + p[2]*s[2];
      n2 = q[0]*d[0] + q[1]*d[1] + q[2]*d[2];
      r.front_face = det > 0;
      if (det < 0) begin
         det = -det;
         nt = -nt;
         n1 = -n1;
         n2 = -n2;
      end
      ok = (n1 >= 0) && (n2 >= 0);
      if (op == OP_QUAD) ok = ok && n1 <= det && n2 <= det;
      else ok = ok && (n1 + n2) <= det;
      scaled = nt <<< T_FRAC;
      lo_b = wide_t'(t_lo) * det;
      hi_b = wide_t'(t_hi) * det;
      ok = ok && lo_b < scaled && scaled < hi_b;
      if (!ok) begin
         r.front_face = 1'b0;
         return r;
      end
      mag = (scaled < 0) ? -scaled : scaled;
      tq  = mag / det;
      ts  = longint'(tq[63:0]);
      if (scaled < 0) ts = -ts;
      bu = (n1 <<< BARY_FRAC) / det;
      bv = (n2 <<< BARY_FRAC) / det;
      lim = wide_t'(1) <<< (COORD_BITS - 1);
      for (int i = 0; i < 3; i++) begin
         // product truncated toward zero before the add
         c = o[i] + (wide_t'(ts) * d[i]) / 65536;
         if (c > lim - 1) c = lim - 1;
         if (c < -lim) c = -lim;
         r.hit_point[i*COORD_BITS +: COORD_BITS] = c[COORD_BITS-1:0];
      end
      r.hit    = 1'b1;
      r.hit_t  = ts[T_BITS-1:0];
      r.bary_u = bu[BARY_BITS-1:0];
      r.bary_v = bv[BARY_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      isect_t exp_r;
      isect_t got;
      if (reset) begin
         fail_count <= 0;
         req_count  <= 0;
         hit_count  <= 0;
         quad_count <= 0;
         isect_q.delete();
      end else begin
         if (req.valid && req.ready) begin
            exp_r = predict_intersection(req.op, req.ray_origin, req.ray_direction,
                                         req.vertex0, req.edge1, req.edge2,
                                         req.t_min, req.t_max);
            isect_q.push_back(exp_r);
            req_count  <= req_count + 1;
            hit_count  <= hit_count + exp_r.hit;
            quad_count <= quad_count + (req.op == OP_QUAD);
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.hit, rsp.hit_t, rsp.bary_u, rsp.bary_v, rsp.front_face,
                    rsp.hit_point};
            if (isect_q.size() == 0) begin
               if (fail_count < 10) $display("ERROR: response with no request pending");
               fail_count <= fail_count + 1;
            end else begin
               exp_r = isect_q.pop_front();
               if (got !== exp_r) begin
                  if (fail_count < 10)
                     $display("ERROR: hit %0b/%0b t %0d/%0d u %0d/%0d v %0d/%0d ff %0b/%0b pt %h/%h (exp/got)",
                              exp_r.hit, got.hit, exp_r.hit_t, got.hit_t,
                              exp_r.bary_u, got.bary_u, exp_r.bary_v, got.bary_v,
                              exp_r.front_face, got.front_face,
                              exp_r.hit_point, got.hit_point);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending = isect_q.size();

endmodule

>>> verif/tb_ray_triangle_quad_intersect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_quad_intersect
// Drives directed and random ray / triangle / parallelogram requests with
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_ray_triangle_quad_intersect;
   import rtqi_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 500;

   typedef struct {
      logic                     op;
      pack_type                 org;
      pack_type                 dir;
      pack_type                 v0;
      pack_type                 e1;
      pack_type                 e2;
      logic signed [T_BITS-1:0] t_lo;
      logic signed [T_BITS-1:0] t_hi;
   } ray_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, req_count, hit_count, quad_count;
   int   idle_cycles = 0;
   int   stall_left = 0;
   logic steady = 1'b0;

   rtqi_req_if req ();
   rtqi_rsp_if rsp ();

   ray_triangle_quad_intersect dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   rtqi_checker chk (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                     .fail_count(fail_count), .pending(pending), .req_count(req_count),
                     .hit_count(hit_count), .quad_count(quad_count));

   always #6 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic pack_type pack3(int x, int y, int z);
      return {z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
   endfunction

   function automatic int rnd(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic pack_type rnd_pack();
      return pack_type'({$urandom, $urandom});
   endfunction

   // ray aimed at a point inside (or just past) the primitive
   function automatic ray_item_t aimed_item();
      ray_item_t it;
      int v[3], a[3], b[3], o[3], tg[3];
      int fa, fb, k;
      it.op = 1'($urandom_range(0, 1));
      fa = $urandom_range(0, 17);
      fb = $urandom_range(0, 17);
      k  = $urandom_range(1, 4);
      for (int i = 0; i < 3; i++) begin
         v[i] = rnd(60000);
         a[i] = rnd(20000);
         b[i] = rnd(20000);
         o[i] = rnd(300000);
         tg[i] = v[i] + a[i] * fa / 16 + b[i] * fb / 16;
      end
      it.org = pack3(o[0], o[1], o[2]);
      it.dir = pack3((tg[0]-o[0])/k, (tg[1]-o[1])/k, (tg[2]-o[2])/k);
      it.v0  = pack3(v[0], v[1], v[2]);
      it.e1  = pack3(a[0], a[1], a[2]);
      it.e2  = pack3(b[0], b[1], b[2]);
      it.t_lo = ($urandom_range(0, 3) == 0) ? rnd(65536) : 0;
      it.t_hi = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 8 << 16);
      return it;
   endfunction

   function automatic ray_item_t noise_item();
      ray_item_t it;
      it.op  = 1'($urandom_range(0, 1));
      it.org = rnd_pack();
      it.dir = rnd_pack();
      it.v0  = rnd_pack();
      it.e1  = rnd_pack();
      it.e2  = rnd_pack();
      it.t_lo = $urandom;
      it.t_hi = ($urandom_range(0, 1) == 0) ? $urandom : 32'sh7fffffff;
      if ($urandom_range(0, 1) == 0) it.t_lo = 32'sh80000000;
      return it;
   endfunction

   task automatic send_item(input ray_item_t it);
      int g;
      req.valid         <= 1'b1;
      req.op            <= it.op;
      req.ray_origin    <= it.org;
      req.ray_direction <= it.dir;
      req.vertex0       <= it.v0;
      req.edge1         <= it.e1;
      req.edge2         <= it.e2;
      req.t_min         <= it.t_lo;
      req.t_max         <= it.t_hi;
      do @(posedge clock); while (!req.ready);
      g = gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready  <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) < 3) begin
         stall_left <= gap_len();
         rsp.ready  <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      ray_item_t it;
      int drain;
      req.valid = 1'b0;
      req.op = OP_TRI;
      req.ray_origin = '0;
      req.ray_direction = '0;
      req.vertex0 = '0;
      req.edge1 = '0;
      req.edge2 = '0;
      req.t_min = '0;
      req.t_max = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: degenerate, extreme and simple geometric cases
      it = '{OP_TRI, '0, '0, '0, '0, '0, 0, 0};
      send_item(it);
      it = '{OP_QUAD, '1, '1, '1, '1, '1, 32'sh80000000, 32'sh7fffffff};
      send_item(it);
      it = '{OP_TRI, pack3(-(1 << 20), (1 << 20) - 1, -(1 << 20)),
             pack3((1 << 20) - 1, -(1 << 20), (1 << 20) - 1),
             pack3((1 << 20) - 1, (1 << 20) - 1, -(1 << 20)),
             pack3(-(1 << 20), 5, (1 << 20) - 1), pack3(7, -(1 << 20), (1 << 20) - 1),
             32'sh80000000, 32'sh7fffffff};
      send_item(it);
      // unit triangle or parallelogram in z=0, rays down from z=4096 and up from z=-4096 at several points
      for (int k = 0; k < 8; k++) begin
         int px, py;
         px = (k % 4) * 1536;
         py = (k / 4) * 3072;
         it = '{k[0], pack3(px, py, 4096), pack3(0, 0, -4096), pack3(0, 0, 0),
                pack3(4096, 0, 0), pack3(0, 4096, 0), 0, 2 << 16};
         send_item(it);
         it.dir = pack3(0, 0, 4096);
         it.org = pack3(px, py, -4096);
         send_item(it);
      end
      // parallel ray, inverted interval, hit exactly at the bounds, far exit
      it = '{OP_TRI, pack3(100, 100, 4096), pack3(4096, 0, 0), '0,
             pack3(4096, 0, 0), pack3(0, 4096, 0), 0, 2 << 16};
      send_item(it);
      it = '{OP_QUAD, pack3(100, 100, 4096), pack3(0, 0, -4096), '0,
             pack3(4096, 0, 0), pack3(0, 4096, 0), 2 << 16, 0};
      send_item(it);
      it.t_lo = 1 << 16;
      it.t_hi = 3 << 16;
      send_item(it);
      it.t_lo = 0;
      it.t_hi = 1 << 16;
      send_item(it);
      it.dir = pack3(0, 0, -1);
      it.org = pack3(100, 100, (1 << 20) - 1);
      it.t_hi = 32'sh7fffffff;
      send_item(it);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 200 && n < 280);
         it = ($urandom_range(0, 99) < 80) ? aimed_item() : noise_item();
         send_item(it);
      end
      steady = 1'b0;
      req.valid <= 1'b0;

      drain = 0;
      while (pending != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (60) @(posedge clock);
      $display("Sent %0d ray tests (%0d parallelogram), %0d predicted hits",
               req_count, quad_count, hit_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
